[hdl/csems_pkg.sv]
// Shared types, codes and tables for the chipset register file and EMS page mapper.
`default_nettype none

package csems_pkg;

	localparam int PAGE_BYTES_LOG2 = 14;
	localparam int MAX_WINDOWS     = 4;

	// bus access codes
	localparam logic [1:0] CMD_IO_WR = 2'd0;
	localparam logic [1:0] CMD_IO_RD = 2'd1;
	localparam logic [1:0] CMD_MEM   = 2'd2;

	// relocation event codes
	localparam logic [1:0] EV_NONE      = 2'd0;
	localparam logic [1:0] EV_RELOC_ON  = 2'd1;
	localparam logic [1:0] EV_RELOC_OFF = 2'd2;

	localparam logic [15:0] INDEX_PORT = 16'h0022;
	localparam logic [15:0] DATA_PORT  = 16'h0023;

	// register offsets within 0x60..0x6f
	localparam logic [3:0] REG_BANK_A   = 4'ha;
	localparam logic [3:0] REG_EMS_CTL  = 4'hb;
	localparam logic [3:0] REG_BANK_C   = 4'hc;
	localparam logic [3:0] REG_EMS_BASE = 4'hd;
	localparam logic [3:0] REG_EMS_EXT  = 4'he;
	localparam logic [3:0] REG_EMS_SIZE = 4'hf;
	localparam logic [3:0] REG_WINDOW   = 4'h6;  // high nibble of a valid index

	localparam logic [13:0] PAGE_PORT_BASE  = 14'h0208;
	localparam logic [6:0]  FRAME_BASE_PAGE = 7'h30;  // 0xC0000 in 16KB pages

	localparam int EMS_ON_BIT = 4;
	localparam int RELOC_BIT  = 6;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] io_port;
		logic [7:0]  write_data;
		logic [20:0] mem_addr;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        claimed;
		logic        ems_hit;
		logic [22:0] phys_addr;
		logic [1:0]  remap_event;
	} rsp_t;

	// register state seen by the page mapper
	typedef struct packed {
		logic       ems_on;
		logic [3:0] frame_sel;
		logic [3:0] port_sel;
		logic [7:0] ext_bits;
		logic [2:0] size_code;
	} regs_view_t;

	typedef struct packed {
		logic unmap_all;
		logic check_all;
	} regs_ctl_t;

	typedef struct packed {
		logic       claimed;
		logic [7:0] rd;
		logic [1:0] ev;
	} regs_rsp_t;

	typedef struct packed {
		logic        claimed;
		logic [7:0]  rd;
		logic        hit;
		logic [22:0] phys;
	} pager_rsp_t;

	function automatic logic [7:0] reg_write_mask(logic [3:0] r);
		logic [7:0] m;
		case (r)
			4'h0: m = 8'h34;
			4'h2: m = 8'h3f;
			4'h3: m = 8'h00;
			4'h4: m = 8'h60;
			4'h6: m = 8'h80;
			4'ha: m = 8'he0;
			4'hc: m = 8'hf0;
			4'hf: m = 8'he6;
			default: m = 8'hff;
		endcase
		return m;
	endfunction

	// revision bits, also the reset value of every register, the banks included
	function automatic logic [7:0] reg_fixed_bits(logic [3:0] r);
		logic [7:0] f;
		case (r)
			4'h0: f = 8'h80;
			4'h4: f = 8'h40;
			default: f = 8'h00;
		endcase
		return f;
	endfunction

	function automatic logic [7:0] layout_bank_a(logic [3:0] code);
		logic [7:0] v;
		case (code)
			4'd1: v = 8'h80;
			4'd2, 4'd5, 4'd9: v = 8'h60;
			4'd3, 4'd4, 4'd6, 4'd7, 4'd10: v = 8'ha0;
			4'd8, 4'd11, 4'd12: v = 8'he0;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] layout_bank_c(logic [3:0] code);
		logic [7:0] v;
		case (code)
			4'd4: v = 8'h80;
			4'd5: v = 8'ha0;
			4'd6: v = 8'hb0;
			4'd7, 4'd11: v = 8'hc0;
			4'd9, 4'd10: v = 8'he0;
			4'd12: v = 8'hf0;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// page below the size limit: 32 pages for code 0, 64 for code 1, all 128 above
	function automatic logic page_fits(logic [6:0] page, logic [2:0] size_code);
		logic ok;
		case (size_code)
			3'd0: ok = (page[6:5] == 2'b00);
			3'd1: ok = !page[6];
			default: ok = 1'b1;
		endcase
		return ok;
	endfunction

endpackage

`default_nettype wire

[hdl/csems_regs.sv]
// Index/data register file at ports 0x22/0x23 with write masks and layout straps.
`default_nettype none

module csems_regs import csems_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire req_t       item,
	input  wire logic       fire,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_layout,
	output regs_view_t      view,
	output regs_ctl_t       ctl,
	output regs_rsp_t       res
);

	logic [7:0] reg_index_q;
	logic [7:0] chip_q [16];

	logic       is_io;
	logic       hit_index;
	logic       hit_data;
	logic       in_range;
	logic [3:0] r;
	logic [7:0] old_val;
	logic [7:0] new_val;
	logic [7:0] mask;
	logic       data_wr;

	assign is_io     = (item.cmd == CMD_IO_WR) || (item.cmd == CMD_IO_RD);
	assign hit_index = is_io && (item.io_port == INDEX_PORT);
	assign hit_data  = is_io && (item.io_port == DATA_PORT);
	assign in_range  = (reg_index_q[7:4] == REG_WINDOW);
	assign r         = reg_index_q[3:0];
	assign old_val   = chip_q[r];
	assign mask      = reg_write_mask(r);
	assign new_val   = (old_val & ~mask) | (item.write_data & mask) | reg_fixed_bits(r);
	assign data_wr   = hit_data && (item.cmd == CMD_IO_WR) && in_range;

	always_comb begin
		view.ems_on    = chip_q[REG_EMS_CTL][EMS_ON_BIT];
		view.frame_sel = chip_q[REG_EMS_BASE][7:4];
		view.port_sel  = chip_q[REG_EMS_BASE][3:0];
		view.ext_bits  = chip_q[REG_EMS_EXT];
		view.size_code = chip_q[REG_EMS_SIZE][7:5];
	end

	always_comb begin
		ctl.unmap_all = 1'b0;
		ctl.check_all = 1'b0;
		if (fire && data_wr) begin
			case (r)
				REG_EMS_CTL:  ctl.unmap_all = old_val[EMS_ON_BIT] | item.write_data[EMS_ON_BIT];
				REG_EMS_BASE: ctl.unmap_all = chip_q[REG_EMS_CTL][EMS_ON_BIT];
				REG_EMS_EXT:  ctl.check_all = 1'b1;
				default: ;
			endcase
		end
	end

	always_comb begin
		res.claimed = hit_index || hit_data;
		res.rd      = 8'h00;
		res.ev      = EV_NONE;
		if (item.cmd == CMD_IO_RD) begin
			if (hit_index)
				res.rd = reg_index_q;
			else if (hit_data && in_range)
				res.rd = old_val;
		end
		if (data_wr && (r == REG_EMS_CTL) && (old_val[RELOC_BIT] != item.write_data[RELOC_BIT]))
			res.ev = item.write_data[RELOC_BIT] ? EV_RELOC_ON : EV_RELOC_OFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_index_q <= 8'h00;
			for (int i = 0; i < 16; i++)
				chip_q[i] <= reg_fixed_bits(4'(i));
		end else begin
			if (fire && hit_index && (item.cmd == CMD_IO_WR))
				reg_index_q <= item.write_data;
			if (fire && data_wr)
				chip_q[r] <= new_val;
			// strap reload of the bank registers
			if (cfg_we) begin
				chip_q[REG_BANK_A] <= layout_bank_a(cfg_layout);
				chip_q[REG_BANK_C] <= layout_bank_c(cfg_layout);
			end
		end
	end

endmodule

`default_nettype wire

[hdl/csems_pager.sv]
// EMS page windows: page port decode, page state and frame address translation.
`default_nettype none

module csems_pager import csems_pkg::*; #(
	parameter int EMS_WINDOWS = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire req_t       item,
	input  wire logic       fire,
	input  wire regs_view_t view,
	input  wire regs_ctl_t  ctl,
	output pager_rsp_t      res
);

	localparam int WIN_W = (EMS_WINDOWS > 1) ? $clog2(EMS_WINDOWS) : 1;

	logic [6:0] page_q   [EMS_WINDOWS];
	logic       enable_q [EMS_WINDOWS];
	logic       mapped_q [EMS_WINDOWS];

	logic [13:0]      port_base;
	logic             port_hit;
	logic [WIN_W-1:0] port_win;
	logic             port_wr;
	logic             wr_en;

	logic [6:0]       addr_page;
	logic [6:0]       frame_page;
	logic [6:0]       slot_diff;
	logic             in_frame;
	logic [WIN_W-1:0] slot;
	logic [1:0]       ext;

	// window i answers at base + i*0x4000 and the port after it
	assign port_base = PAGE_PORT_BASE + {6'd0, view.port_sel, 4'd0};
	assign port_win  = item.io_port[PAGE_BYTES_LOG2 +: WIN_W];
	assign port_hit  = view.ems_on
		&& ((item.cmd == CMD_IO_WR) || (item.cmd == CMD_IO_RD))
		&& (item.io_port[13:1] == port_base[13:1])
		&& ({1'b0, item.io_port[15:14]} < 3'(EMS_WINDOWS));
	assign port_wr   = fire && port_hit && (item.cmd == CMD_IO_WR);
	assign wr_en     = item.write_data[7] && page_fits(item.write_data[6:0], view.size_code);

	// frame base is page aligned, so the slot is a difference of page numbers
	assign addr_page  = item.mem_addr[20:PAGE_BYTES_LOG2];
	assign frame_page = FRAME_BASE_PAGE + {3'd0, view.frame_sel};
	assign slot_diff  = addr_page - frame_page;
	assign in_frame   = (addr_page >= frame_page) && (slot_diff < 7'(EMS_WINDOWS));
	assign slot       = slot_diff[WIN_W-1:0];

	always_comb begin
		case (slot_diff[1:0])
			2'd0: ext = view.ext_bits[7:6];
			2'd1: ext = view.ext_bits[5:4];
			2'd2: ext = view.ext_bits[3:2];
			default: ext = view.ext_bits[1:0];
		endcase
	end

	always_comb begin
		res.claimed = port_hit;
		res.rd      = 8'h00;
		res.hit     = 1'b0;
		res.phys    = '0;
		if (port_hit && (item.cmd == CMD_IO_RD))
			res.rd = item.io_port[0] ? 8'hff : {enable_q[port_win], page_q[port_win]};
		if ((item.cmd == CMD_MEM) && view.ems_on && in_frame && mapped_q[slot]) begin
			res.hit  = 1'b1;
			res.phys = {ext, page_q[slot], item.mem_addr[PAGE_BYTES_LOG2-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < EMS_WINDOWS; w++) begin
				page_q[w]   <= 7'd0;
				enable_q[w] <= 1'b0;
				mapped_q[w] <= 1'b0;
			end
		end else if (fire) begin
			for (int w = 0; w < EMS_WINDOWS; w++) begin
				if (port_wr && (port_win == WIN_W'(w))) begin
					page_q[w]   <= item.write_data[6:0];
					enable_q[w] <= wr_en;
					mapped_q[w] <= wr_en;
				end else if (ctl.check_all) begin
					enable_q[w] <= enable_q[w] && page_fits(page_q[w], view.size_code);
					mapped_q[w] <= enable_q[w] && page_fits(page_q[w], view.size_code);
				end else if (ctl.unmap_all) begin
					mapped_q[w] <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

[hdl/chipset_regs_with_ems_paging_unit.sv]
// Chipset register file with EMS page mapper: top level with input and result registers.
//
// Each item on the req channel is one bus access: an io write, an io read, or a
// memory address to translate. Every item gives exactly one rsp item: io read
// data and claim flag, the EMS hit with its physical offset, and a relocation
// event on writes to register 0x6b.
// An item is taken into the input register, then decoded, applied to the
// register and page state, and written to the result register.
// rsp_valid rises when the item moves from the input register into the result register;
// one item per cycle is sustained while rsp_stall is low. State updates in program order, so each item sees every
// earlier write.
// When rsp_stall holds a result, one more item waits in the input register and
// req_stall rises after that; nothing is dropped.
// The cfg channel loads the memory layout code; the bank registers 0x6a and
// 0x6c take the strap values at that edge. cfg_ready is always high.
// Reset clears the index, the page windows, and puts the registers at their
// revision values with the bank bits of layout code 0.
`default_nettype none

module chipset_regs_with_ems_paging_unit import csems_pkg::*; #(
	parameter int EMS_WINDOWS = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire req_t       req,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output rsp_t            rsp,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] cfg_data
);

	logic       valid_s1;
	req_t       req_s1;
	logic       rsp_valid_q;
	rsp_t       rsp_q;
	logic       advance;
	logic       take;
	rsp_t       rsp_d;

	regs_view_t view;
	regs_ctl_t  ctl;
	regs_rsp_t  regs_res;
	pager_rsp_t pager_res;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && rsp_valid_q && rsp_stall;
	assign take      = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	csems_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (req_s1),
		.fire       (advance),
		.cfg_we     (cfg_valid),
		.cfg_layout (cfg_data),
		.view       (view),
		.ctl        (ctl),
		.res        (regs_res)
	);

	csems_pager #(
		.EMS_WINDOWS (EMS_WINDOWS)
	) u_pager (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (req_s1),
		.fire   (advance),
		.view   (view),
		.ctl    (ctl),
		.res    (pager_res)
	);

	always_comb begin
		rsp_d             = '0;
		rsp_d.remap_event = regs_res.ev;
		rsp_d.ems_hit     = pager_res.hit;
		rsp_d.phys_addr   = pager_res.phys;
		if (regs_res.claimed) begin
			rsp_d.claimed   = 1'b1;
			rsp_d.read_data = regs_res.rd;
		end else if (pager_res.claimed) begin
			rsp_d.claimed   = 1'b1;
			rsp_d.read_data = pager_res.rd;
		end else if (req_s1.cmd == CMD_IO_RD) begin
			rsp_d.read_data = 8'hff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			req_s1 <= req;
		if (advance)
			rsp_q <= rsp_d;
	end

endmodule

`default_nettype wire

[hdl/csems_chk.sv]
// Port checker for the chipset register unit and its bind to the top level.
`default_nettype none

module csems_chk import csems_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_io_mem_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.claimed && rsp.ems_hit))
		else $error("item both claimed as io and hit as memory");

	a_phys_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ems_hit |-> rsp.phys_addr == 23'd0)
		else $error("physical address without a hit");

	a_event_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.remap_event != EV_NONE) |-> rsp.claimed && (rsp.read_data == 8'h00))
		else $error("relocation event on an item that is not a register write");

endmodule

bind chipset_regs_with_ems_paging_unit csems_chk u_csems_chk (.*);

`default_nettype wire
